// ===== src/lfr_pkg.sv =====
// Package with the shared widths, function codes and parameter defaults of the LCD refresh block.
`default_nettype none

package lfr_pkg;

  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;

  localparam int DEF_ROW_BYTES = 40;
  localparam int DEF_ROWS      = 80;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_WRITE = 2'd0;
  localparam func_t FUNC_TICK  = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

endpackage

`default_nettype wire

// ===== src/lfr_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none

interface lfr_in_if;
  import lfr_pkg::*;
  logic                valid;
  logic                ready;
  func_t               func;
  logic [ADDR_W-1:0]   byte_address;
  logic [BYTE_W-1:0]   byte_value;

  modport source (output valid, func, byte_address, byte_value, input ready);
  modport sink   (input valid, func, byte_address, byte_value, output ready);
endinterface

interface lfr_out_if;
  import lfr_pkg::*;
  logic               valid;
  logic               ready;
  logic [NIB_W-1:0]   high_nibble;
  logic [NIB_W-1:0]   low_nibble;
  logic               row_latch;
  logic               frame_mark;

  modport source (output valid, high_nibble, low_nibble, row_latch, frame_mark, input ready);
  modport sink   (input valid, high_nibble, low_nibble, row_latch, frame_mark, output ready);
endinterface

interface lfr_cfg_if;
  logic valid;
  logic ready;
  logic refresh_enable;

  modport source (output valid, refresh_enable, input ready);
  modport sink   (input valid, refresh_enable, output ready);
endinterface

`default_nettype wire

// ===== src/lfr_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module lfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/lcd_frame_buffer_refresh_top.sv =====
// Top level of the passive LCD row refresh controller with its byte frame store.
//
//   Channel   Dir  Beat carries
//   in_chan   in   func, byte_address, byte_value
//   out_chan  out  high_nibble, low_nibble, row_latch, frame_mark
//   cfg_chan  in   refresh_enable (write clears the row position)
//
// A byte write, a disabled tick or an unused code leaves the controller idle.
// An enabled tick starts a row that reads the store byte by byte while the result buffer has
// room; the next item is accepted only after the last byte of the row has been read.
// A row's first beat passes the row state, the store read and the output register in turn.
// A clear sweeps the store one byte per cycle.
// The store is undefined after reset; software must clear it first (unenforced).
// Result stalls are absorbed by an output register and a skid register.
`default_nettype none

module lcd_frame_buffer_refresh_top #(
  parameter int ROW_BYTES = lfr_pkg::DEF_ROW_BYTES,
  parameter int ROWS      = lfr_pkg::DEF_ROWS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lfr_in_if.sink    in_chan,
  lfr_out_if.source out_chan,
  lfr_cfg_if.sink   cfg_chan
);

  import lfr_pkg::*;

  localparam int StoreSize = ROW_BYTES * ROWS;
  localparam int AW        = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int ColW      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int RowW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WideW     = (AW > ADDR_W) ? AW : ADDR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CLEAR
  } state_e;

  state_e          state_q;
  logic            en_q;
  logic [RowW-1:0] row_q;
  logic [AW-1:0]   base_q;
  logic [ColW-1:0] col_q;
  logic [AW-1:0]   clr_q;
  logic            frame_q;

  logic            pend_q;
  logic            pend_last_q;
  logic            pend_mark_q;
  logic            out_v_q;
  logic            skid_v_q;

  logic [NIB_W-1:0] out_hi_q, out_lo_q, skid_hi_q, skid_lo_q;
  logic             out_latch_q, out_mark_q, skid_latch_q, skid_mark_q;

  logic             in_acc, cfg_acc, pop, issue, last_col, last_row, clr_last;
  logic [1:0]       occ;
  logic [WideW-1:0] wr_wide;
  logic             wr_ok;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  assign in_chan.ready  = (state_q == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc  = in_chan.valid & in_chan.ready;
  assign cfg_acc = cfg_chan.valid & cfg_chan.ready;

  assign pop      = out_v_q & out_chan.ready;
  assign occ      = 2'(out_v_q) + 2'(skid_v_q) + 2'(pend_q);
  assign issue    = (state_q == ST_ROW) && ((occ - 2'(pop)) < 2'd2);
  assign last_col = (col_q == ColW'(ROW_BYTES - 1));
  assign last_row = (row_q == RowW'(ROWS - 1));
  assign clr_last = (clr_q == AW'(StoreSize - 1));

  assign wr_wide = WideW'(in_chan.byte_address);
  assign wr_ok   = (wr_wide < WideW'(StoreSize));

  assign mem_we    = (state_q == ST_CLEAR) ||
                     (in_acc && (in_chan.func == FUNC_WRITE) && wr_ok);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(wr_wide);
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : in_chan.byte_value;
  assign mem_raddr = base_q + AW'(col_q);

  lfr_ram #(
    .Width (BYTE_W),
    .Depth (StoreSize),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      row_q       <= '0;
      base_q      <= '0;
      col_q       <= '0;
      clr_q       <= '0;
      frame_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      pend_mark_q <= 1'b0;
      out_v_q     <= 1'b0;
      skid_v_q    <= 1'b0;
    end else begin
      if (cfg_acc) begin
        en_q   <= cfg_chan.refresh_enable;
        row_q  <= '0;
        base_q <= '0;
      end

      pend_q <= issue;
      if (issue) begin
        pend_last_q <= last_col;
        pend_mark_q <= frame_q;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_chan.func == FUNC_TICK && en_q) begin
              state_q <= ST_ROW;
              col_q   <= '0;
            end else if (in_chan.func == FUNC_CLEAR) begin
              state_q <= ST_CLEAR;
              clr_q   <= '0;
            end
          end
        end
        ST_ROW: begin
          if (issue) begin
            col_q <= col_q + ColW'(1);
            if (last_col) begin
              state_q <= ST_IDLE;
              if (last_row) begin
                row_q   <= '0;
                base_q  <= '0;
                frame_q <= 1'b1;
              end else begin
                row_q   <= row_q + RowW'(1);
                base_q  <= base_q + AW'(ROW_BYTES);
                frame_q <= 1'b0;
              end
            end
          end
        end
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (pop) begin
        if (skid_v_q) begin
          skid_v_q <= pend_q;
        end else if (!pend_q) begin
          out_v_q <= 1'b0;
        end
      end else if (pend_q) begin
        if (!out_v_q) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_v_q) begin
      out_hi_q    <= skid_hi_q;
      out_lo_q    <= skid_lo_q;
      out_latch_q <= skid_latch_q;
      out_mark_q  <= skid_mark_q;
    end else if (pend_q && (pop || !out_v_q)) begin
      out_hi_q    <= mem_rdata[7:4];
      out_lo_q    <= mem_rdata[3:0];
      out_latch_q <= pend_last_q;
      out_mark_q  <= pend_mark_q;
    end
    if (pend_q && ((pop && skid_v_q) || (!pop && out_v_q))) begin
      skid_hi_q    <= mem_rdata[7:4];
      skid_lo_q    <= mem_rdata[3:0];
      skid_latch_q <= pend_last_q;
      skid_mark_q  <= pend_mark_q;
    end
  end

  assign out_chan.valid       = out_v_q;
  assign out_chan.high_nibble = out_hi_q;
  assign out_chan.low_nibble  = out_lo_q;
  assign out_chan.row_latch   = out_latch_q;
  assign out_chan.frame_mark  = out_mark_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= 2'd2)
    else $error("result buffer overcommitted");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a beat while the output register is empty");

  a_tick_starts_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_chan.func == FUNC_TICK) && en_q) |=> (state_q == ST_ROW))
    else $error("enabled tick did not start a row");

  a_no_read_outside_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == ST_ROW))
    else $error("store read issued outside a row");

endmodule

`default_nettype wire

// ===== test/lcd_frame_buffer_refresh_top_test.sv =====
// Self-checking testbench for the LCD row refresh controller: a directed table, then random traffic.
`timescale 1ns / 1ps

module lcd_frame_buffer_refresh_top_test;
  import lfr_pkg::*;

  localparam int ROW_BYTES     = DEF_ROW_BYTES;
  localparam int ROWS          = DEF_ROWS;
  localparam int STORE_SIZE    = ROW_BYTES * ROWS;
  localparam int SETTLE_CYCLES = STORE_SIZE + 64;
  localparam int N_DIRECTED    = 20;
  localparam int MAX_REPORTS   = 10;
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [NIB_W-1:0] high_nibble;
    logic [NIB_W-1:0] low_nibble;
    logic             row_latch;
    logic             frame_mark;
  } lcd_beat_t;

  typedef struct packed {
    logic      is_cfg;
    logic      enable_value;
    func_t     func;
    addr_t     byte_address;
    byte_t     byte_value;
    logic      has_first;
    lcd_beat_t first_beat;
  } stim_row_t;

  localparam lcd_beat_t NO_BEAT = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  byte_t       shadow_store [STORE_SIZE];
  int unsigned scan_row;
  logic        frame_level;
  logic        scan_enable;
  lcd_beat_t   pending_beats [$];
  int          error_count;
  logic        drain_fast;
  stim_row_t   directed_rows [N_DIRECTED];

  lfr_in_if  in_bus ();
  lfr_out_if out_bus ();
  lfr_cfg_if cfg_bus ();

  lcd_frame_buffer_refresh_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #2 clk_i = ~clk_i;

  function automatic void predict_row_scan(func_t f, addr_t a, byte_t v);
    byte_t       b;
    lcd_beat_t   beat;
    int unsigned base;
    case (f)
      FUNC_WRITE: begin
        if (a < STORE_SIZE) shadow_store[a] = v;
      end
      FUNC_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
      end
      FUNC_TICK: begin
        if (scan_enable) begin
          base = scan_row * ROW_BYTES;
          for (int k = 0; k < ROW_BYTES; k++) begin
            b = shadow_store[base + k];
            beat.high_nibble = b[7:4];
            beat.low_nibble  = b[3:0];
            beat.row_latch   = (k == ROW_BYTES - 1);
            beat.frame_mark  = frame_level;
            pending_beats.push_back(beat);
          end
          frame_level = 1'b0;
          scan_row++;
          if (scan_row >= ROWS) begin
            scan_row    = 0;
            frame_level = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(func_t f, addr_t a, byte_t v, int gap, logic has_first,
                           lcd_beat_t first);
    if (gap > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid        <= 1'b1;
    in_bus.func         <= f;
    in_bus.byte_address <= a;
    in_bus.byte_value   <= v;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    predict_row_scan(f, a, v);
    if (has_first && pending_beats.size() >= ROW_BYTES)
      pending_beats[pending_beats.size() - ROW_BYTES] = first;
  endtask

  task automatic write_enable(logic en);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.refresh_enable <= en;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    scan_enable = en;
    scan_row    = 0;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    int    pick;
    int    gap;
    int    quiet_items;
    func_t f;
    addr_t a;
    byte_t v;
    quiet_items = 0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      a    = addr_t'($urandom_range(0, (1 << ADDR_W) - 1));
      v    = byte_t'($urandom_range(0, (1 << BYTE_W) - 1));
      if (pick < 48) begin
        f = FUNC_TICK;
      end else if (pick < 88) begin
        f = FUNC_WRITE;
        if (pick < 68) a = addr_t'(scan_row * ROW_BYTES + $urandom_range(0, ROW_BYTES - 1));
        else a = addr_t'($urandom_range(0, STORE_SIZE - 1));
      end else if (pick < 94) begin
        f = FUNC_WRITE;
        a = addr_t'($urandom_range(STORE_SIZE, (1 << ADDR_W) - 1));
      end else if (pick < 98) begin
        f = FUNC_UNUSED;
      end else begin
        f = FUNC_CLEAR;
      end
      gap = 0;
      if (drain_fast) begin
        gap = 0;
      end else if (quiet_items > 0) begin
        quiet_items--;
      end else if ($urandom_range(0, 19) == 0) begin
        quiet_items = $urandom_range(10, 30);
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
      end
      send_item(f, a, v, gap, 1'b0, NO_BEAT);
    end
  endtask

  // The result sink stalls in random bursts, with calm stretches in between.
  initial begin
    int stall_left;
    int calm_left;
    out_bus.ready = 1'b0;
    stall_left    = 0;
    calm_left     = 0;
    forever begin
      @(negedge clk_i);
      if (drain_fast || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1: begin
            stall_left = $urandom_range(0, 12);
            out_bus.ready <= 1'b0;
          end
          2: begin
            calm_left = $urandom_range(50, 300);
            out_bus.ready <= 1'b1;
          end
          default: out_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  // Each accepted result beat is compared with the oldest expected beat.
  always @(posedge clk_i) begin
    lcd_beat_t got;
    lcd_beat_t want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.high_nibble = out_bus.high_nibble;
      got.low_nibble  = out_bus.low_nibble;
      got.row_latch   = out_bus.row_latch;
      got.frame_mark  = out_bus.frame_mark;
      if (pending_beats.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected beat: hi %h lo %h latch %b mark %b",
                   got.high_nibble, got.low_nibble, got.row_latch, got.frame_mark);
      end else begin
        want = pending_beats.pop_front();
        if (got.high_nibble !== want.high_nibble || got.low_nibble !== want.low_nibble ||
            got.row_latch !== want.row_latch || got.frame_mark !== want.frame_mark) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("beat mismatch: exp hi %h lo %h latch %b mark %b,",
                     want.high_nibble, want.low_nibble, want.row_latch, want.frame_mark,
                     " got hi %h lo %h latch %b mark %b",
                     got.high_nibble, got.low_nibble, got.row_latch, got.frame_mark);
        end
      end
    end
  end

  initial begin
    stim_row_t r;
    int        gap;
    in_bus.valid           = 1'b0;
    in_bus.func            = FUNC_WRITE;
    in_bus.byte_address    = '0;
    in_bus.byte_value      = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.refresh_enable = 1'b0;
    rst_ni                 = 1'b0;
    drain_fast             = 1'b0;
    error_count            = 0;
    scan_row               = 0;
    frame_level            = 1'b0;
    scan_enable            = 1'b0;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    // The store is cleared before any row is read out.
    directed_rows = '{
      '{1'b0, 1'b0, FUNC_CLEAR,  12'd0,    8'h00, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_TICK,   12'd0,    8'h00, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_UNUSED, 12'd0,    8'h00, 1'b0, NO_BEAT},
      '{1'b1, 1'b1, FUNC_WRITE,  12'd0,    8'h00, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_TICK,   12'hFFF,  8'hFF, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, FUNC_WRITE,  12'd40,   8'hFF, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_WRITE,  12'd79,   8'h5A, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_TICK,   12'd0,    8'h00, 1'b1, '{4'hF, 4'hF, 1'b0, 1'b0}},
      '{1'b0, 1'b0, FUNC_WRITE,  12'd3199, 8'hA5, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_WRITE,  12'd3200, 8'hFF, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_WRITE,  12'hFFF,  8'hFF, 1'b0, NO_BEAT},
      '{1'b1, 1'b0, FUNC_WRITE,  12'd0,    8'h00, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_TICK,   12'd0,    8'h00, 1'b0, NO_BEAT},
      '{1'b1, 1'b1, FUNC_WRITE,  12'd0,    8'h00, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_WRITE,  12'd0,    8'h80, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_TICK,   12'd0,    8'h00, 1'b1, '{4'h8, 4'h0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, FUNC_CLEAR,  12'hFFF,  8'hFF, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_TICK,   12'd0,    8'h00, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, FUNC_UNUSED, 12'hFFF,  8'hFF, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, FUNC_WRITE,  12'd119,  8'h3C, 1'b0, NO_BEAT}
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.is_cfg) begin
        write_enable(r.enable_value);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        send_item(r.func, r.byte_address, r.byte_value, gap, r.has_first, r.first_beat);
      end
    end

    write_enable(1'b1);
    run_random(200);
    write_enable(1'b0);
    run_random(40);
    write_enable(1'b1);
    run_random(120);
    drain_fast = 1'b1;
    run_random(60);

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
